@@ sv/rdc_pkg.sv @@
package rdc_pkg;

  // Width of the number and depth of the digit store
  localparam int NUMBER_WIDTH = 31;
  localparam int MAX_DIGITS   = 31;

  // Fixed field widths
  localparam int DIGIT_W = 6;
  localparam int OCOUNT_W = 5;

  // Internal counter widths
  localparam int COUNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W   = $clog2(NUMBER_WIDTH);

  // Radix limits
  localparam logic [DIGIT_W-1:0] BASE_MIN = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX = 6'd36;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

@@ sv/radix_digit_converter.sv @@
// Radix digit converter.
// Pulse start with number and base while busy is low; the item is taken at
// that edge and busy rises in the next cycle. base values below 2 act as 2,
// values above 36 act as 36.
// The number is divided by the base over and over in one shared
// shift-subtract divider, one quotient bit per cycle, and each remainder is
// then stored as a digit in a separate step. Digits are pushed into a shift
// line, least significant first, and then shifted back out so that the most
// significant digit leaves first.
// Results: valid is high for one cycle per digit, with digit, digit_count
// and is_last (set on the least significant digit). The first digit is on
// the outputs once the last division and its store are done; the D digits,
// D being the digit count, follow on consecutive cycles, and busy falls
// after the last one.
// The receiver cannot stall: each result is shown once for one cycle.
// A zero number gives the single digit 0.
// Reset (rst, synchronous) returns the block to idle at once and drops any
// item in progress; the digit store needs no clearing.
module radix_digit_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rdc_pkg::NUMBER_WIDTH-1:0]  number,
  input  logic [rdc_pkg::DIGIT_W-1:0]       base,
  output logic                              valid,
  output logic [rdc_pkg::DIGIT_W-1:0]       digit,
  output logic [rdc_pkg::OCOUNT_W-1:0]      digit_count,
  output logic                              is_last
);
  import rdc_pkg::*;

  state_t                  state, state_next;
  logic [NUMBER_WIDTH-1:0] quot, quot_next;
  logic [DIGIT_W-1:0]      rem, rem_next;
  logic [DIGIT_W-1:0]      base_r, base_r_next;
  logic [BIT_W-1:0]        bit_cnt, bit_cnt_next;
  logic [COUNT_W-1:0]      count, count_next;
  logic [COUNT_W-1:0]      left, left_next;
  digit_t                  store [MAX_DIGITS];
  logic                    push, pop;

  // Shared divider step: shift in next dividend bit, subtract if it fits
  logic [DIGIT_W:0] trial;
  logic             fits;
  assign trial = {rem, quot[NUMBER_WIDTH-1]};
  assign fits  = (trial >= {1'b0, base_r});

  // Sequencer
  always_comb begin
    state_next   = state;
    quot_next    = quot;
    rem_next     = rem;
    base_r_next  = base_r;
    bit_cnt_next = bit_cnt;
    count_next   = count;
    left_next    = left;
    push         = 1'b0;
    pop          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          quot_next    = number;
          rem_next     = '0;
          bit_cnt_next = '0;
          count_next   = '0;
          if (base < BASE_MIN) begin
            base_r_next = BASE_MIN;
          end else if (base > BASE_MAX) begin
            base_r_next = BASE_MAX;
          end else begin
            base_r_next = base;
          end
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        quot_next = {quot[NUMBER_WIDTH-2:0], fits};
        rem_next  = fits ? DIGIT_W'(trial - {1'b0, base_r}) : trial[DIGIT_W-1:0];
        bit_cnt_next = bit_cnt + 1'b1;
        if (bit_cnt == BIT_W'(NUMBER_WIDTH - 1)) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        // rem holds the digit, quot the next dividend
        push = 1'b1;
        if (count != COUNT_W'(MAX_DIGITS)) begin
          count_next = count + 1'b1;
        end
        rem_next     = '0;
        bit_cnt_next = '0;
        if (quot == '0) begin
          left_next  = (count != COUNT_W'(MAX_DIGITS)) ? count + 1'b1 : count;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_EMIT: begin
        pop       = 1'b1;
        left_next = left - 1'b1;
        if (left == COUNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      quot    <= '0;
      count   <= '0;
      left    <= '0;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      quot    <= quot_next;
      count   <= count_next;
      left    <= left_next;
      bit_cnt <= bit_cnt_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem    <= rem_next;
    base_r <= base_r_next;
  end

  // Digit shift line: newest digit at the bottom, oldest falls off the top
  always_ff @(posedge clk) begin
    if (push) begin
      store[0] <= rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        store[i] <= store[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        store[i] <= store[i+1];
      end
    end
  end

  // Outputs
  assign busy        = (state != ST_IDLE);
  assign valid       = (state == ST_EMIT);
  assign digit       = store[0];
  assign digit_count = OCOUNT_W'(count);
  assign is_last     = (state == ST_EMIT) && (left == COUNT_W'(1));

  // Checks
  a_valid_busy : assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result outside a conversion");
  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    valid && is_last |=> !valid && !busy) else $error("run continues after last digit");
  a_take : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !valid) else $error("item not taken");
  a_digit_range : assert property (@(posedge clk) disable iff (rst)
    valid |-> digit < base_r) else $error("digit not below base");
  a_count_nz : assert property (@(posedge clk) disable iff (rst)
    valid |-> count != '0 && left <= count) else $error("bad digit count");

endmodule
